// ----- rtl/irpdt_pkg.sv -----
// shared types, register map and constants of the ir pulse-distance transmitter
`timescale 1ns / 1ps
`default_nettype none
package irpdt_pkg;

   // register file geometry
   localparam int unsigned NUM_REGS   = 7;
   localparam int unsigned ADDR_W     = 5;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned CMD_W      = 8;
   localparam int unsigned IDX_W      = 3;

   // register indexes (byte address is 4 * index)
   localparam logic [IDX_W-1:0] REG_HDR_MARK   = 3'd0;
   localparam logic [IDX_W-1:0] REG_HDR_SPACE  = 3'd1;
   localparam logic [IDX_W-1:0] REG_BIT_MARK   = 3'd2;
   localparam logic [IDX_W-1:0] REG_ONE_SPACE  = 3'd3;
   localparam logic [IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
   localparam logic [IDX_W-1:0] REG_RPT_MARK   = 3'd5;
   localparam logic [IDX_W-1:0] REG_RPT_SPACE  = 3'd6;

   // reset values in ticks
   localparam logic [LEN_W-1:0] RST_HDR_MARK   = 16'd9000;
   localparam logic [LEN_W-1:0] RST_HDR_SPACE  = 16'd4500;
   localparam logic [LEN_W-1:0] RST_BIT_MARK   = 16'd562;
   localparam logic [LEN_W-1:0] RST_ONE_SPACE  = 16'd1687;
   localparam logic [LEN_W-1:0] RST_ZERO_SPACE = 16'd562;
   localparam logic [LEN_W-1:0] RST_RPT_MARK   = 16'd8000;
   localparam logic [LEN_W-1:0] RST_RPT_SPACE  = 16'd8000;

   // frame sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HDR_MARK  = 3'd1,
      PH_HDR_SPACE = 3'd2,
      PH_BIT_MARK  = 3'd3,
      PH_BIT_SPACE = 3'd4,
      PH_RPT_MARK  = 3'd5,
      PH_RPT_SPACE = 3'd6
   } phase_type;

   // segment lengths handed from the register file to the sequencer
   typedef struct packed {
      logic [LEN_W-1:0] hdr_mark;
      logic [LEN_W-1:0] hdr_space;
      logic [LEN_W-1:0] bit_mark;
      logic [LEN_W-1:0] one_space;
      logic [LEN_W-1:0] zero_space;
      logic [LEN_W-1:0] rpt_mark;
      logic [LEN_W-1:0] rpt_space;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic busy;
      logic mark;
   } result_type;

   // a zero length runs for one tick
   function automatic logic [LEN_W-1:0] seg_len(input logic [LEN_W-1:0] len);
      seg_len = (len == '0) ? LEN_W'(1) : len;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ir_pulse_distance_transmitter_core.sv -----
// top level of the ir pulse-distance transmitter envelope generator
//
//   channel  direction  tdata fields (low bit up)
//   req      in         start_req[0], command[8:1], hold[9], zero pad to 16
//   rsp      out        mark[0], busy_res[1], zero pad to 8
//   csr      apb        seven 16-bit segment lengths at byte address 4*i
//
// each req transfer is one tick; its result sits in the rsp register in the next cycle
// one tick per cycle sustained while rsp_tready stays high, through the single rsp output register
// reset idles the sequencer and loads the default lengths; no clearing pass
// a stalled rsp holds req_tready low until the held result is taken
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_distance_transmitter_core #(
   parameter int unsigned BITS_PER_FRAME = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // tick stream
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [15:0]                  req_tdata,  // start_req, command, hold
   // envelope stream
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [7:0]                   rsp_tdata,  // mark, busy_res
   // register port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [irpdt_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready
);
   import irpdt_pkg::*;

   cfg_type    cfg;
   result_type seq_result;
   result_type rsp_result;
   logic       req_xfer;

   assign csr_pready = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;

   // segment length registers
   irpdt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // frame sequencer
   irpdt_seq #(
      .BITS_PER_FRAME (BITS_PER_FRAME)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (req_xfer),
      .start_req (req_tdata[0]),
      .command   (req_tdata[CMD_W:1]),
      .hold      (req_tdata[CMD_W+1]),
      .cfg       (cfg),
      .result    (seq_result)
   );

   // result register
   irpdt_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (seq_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {6'b0, rsp_result.busy, rsp_result.mark};

endmodule
`default_nettype wire

// ----- rtl/irpdt_csr.sv -----
// apb register file holding the segment lengths
`timescale 1ns / 1ps
`default_nettype none
module irpdt_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [irpdt_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output irpdt_pkg::cfg_type               cfg
);
   import irpdt_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [IDX_W-1:0] idx;
   logic             wr_en;
   logic [LEN_W-1:0] wval;
   logic [LEN_W-1:0] rval;

   assign idx   = paddr[ADDR_W-1:2];
   assign wr_en = psel && penable && pwrite;
   assign wval  = pwdata[LEN_W-1:0];

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_HDR_MARK:   cfg_in.hdr_mark   = wval;
            REG_HDR_SPACE:  cfg_in.hdr_space  = wval;
            REG_BIT_MARK:   cfg_in.bit_mark   = wval;
            REG_ONE_SPACE:  cfg_in.one_space  = wval;
            REG_ZERO_SPACE: cfg_in.zero_space = wval;
            REG_RPT_MARK:   cfg_in.rpt_mark   = wval;
            REG_RPT_SPACE:  cfg_in.rpt_space  = wval;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hdr_mark   <= RST_HDR_MARK;
         cfg_ff.hdr_space  <= RST_HDR_SPACE;
         cfg_ff.bit_mark   <= RST_BIT_MARK;
         cfg_ff.one_space  <= RST_ONE_SPACE;
         cfg_ff.zero_space <= RST_ZERO_SPACE;
         cfg_ff.rpt_mark   <= RST_RPT_MARK;
         cfg_ff.rpt_space  <= RST_RPT_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_HDR_MARK:   rval = cfg_ff.hdr_mark;
         REG_HDR_SPACE:  rval = cfg_ff.hdr_space;
         REG_BIT_MARK:   rval = cfg_ff.bit_mark;
         REG_ONE_SPACE:  rval = cfg_ff.one_space;
         REG_ZERO_SPACE: rval = cfg_ff.zero_space;
         REG_RPT_MARK:   rval = cfg_ff.rpt_mark;
         REG_RPT_SPACE:  rval = cfg_ff.rpt_space;
         default:        rval = '0;
      endcase
   end

   assign prdata = {{(32 - LEN_W){1'b0}}, rval};
   assign cfg    = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/irpdt_seq.sv -----
// frame sequencer: phase, segment countdown, shift register and bit counter
`timescale 1ns / 1ps
`default_nettype none
module irpdt_seq #(
   parameter int unsigned BITS_PER_FRAME = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       start_req,
   input  wire logic [irpdt_pkg::CMD_W-1:0] command,
   input  wire logic                       hold,
   input  wire irpdt_pkg::cfg_type         cfg,
   output irpdt_pkg::result_type           result
);
   import irpdt_pkg::*;

   localparam int unsigned BW = $clog2(BITS_PER_FRAME + 1);

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] remaining_ff, remaining_in;
   logic [CMD_W-1:0] shift_ff, shift_in;
   logic [BW-1:0]    bits_ff, bits_in;

   // state as seen after a possible start on this tick
   phase_type        cur_phase;
   logic [LEN_W-1:0] cur_rem;
   logic [CMD_W-1:0] cur_shift;
   logic [BW-1:0]    cur_bits;
   logic [BW-1:0]    bits_dec;
   logic             seg_end;

   always_comb begin
      if (phase_ff == PH_IDLE && start_req) begin
         cur_phase = PH_HDR_MARK;
         cur_rem   = seg_len(cfg.hdr_mark);
         cur_shift = command;
         cur_bits  = BW'(BITS_PER_FRAME);
      end else begin
         cur_phase = phase_ff;
         cur_rem   = remaining_ff;
         cur_shift = shift_ff;
         cur_bits  = bits_ff;
      end
   end

   assign seg_end  = (cur_rem <= LEN_W'(1));
   assign bits_dec = (cur_bits != '0) ? cur_bits - BW'(1) : '0;

   // next state
   always_comb begin
      phase_in     = cur_phase;
      remaining_in = cur_rem - LEN_W'(1);
      shift_in     = cur_shift;
      bits_in      = cur_bits;
      if (seg_end) begin
         case (cur_phase)
            PH_HDR_MARK: begin
               phase_in     = PH_HDR_SPACE;
               remaining_in = seg_len(cfg.hdr_space);
            end
            PH_HDR_SPACE: begin
               phase_in     = PH_BIT_MARK;
               remaining_in = seg_len(cfg.bit_mark);
            end
            PH_BIT_MARK: begin
               phase_in     = PH_BIT_SPACE;
               remaining_in = cur_shift[0] ? seg_len(cfg.one_space)
                                           : seg_len(cfg.zero_space);
            end
            PH_BIT_SPACE: begin
               shift_in = {1'b0, cur_shift[CMD_W-1:1]};
               bits_in  = bits_dec;
               if (bits_dec != '0) begin
                  phase_in     = PH_BIT_MARK;
                  remaining_in = seg_len(cfg.bit_mark);
               end else begin
                  phase_in     = PH_RPT_MARK;
                  remaining_in = seg_len(cfg.rpt_mark);
               end
            end
            PH_RPT_MARK: begin
               phase_in     = PH_RPT_SPACE;
               remaining_in = seg_len(cfg.rpt_space);
            end
            PH_RPT_SPACE: begin
               if (hold) begin
                  phase_in     = PH_RPT_MARK;
                  remaining_in = seg_len(cfg.rpt_mark);
               end else begin
                  phase_in     = PH_IDLE;
                  remaining_in = '0;
               end
            end
            default: begin
               phase_in     = PH_IDLE;
               remaining_in = '0;
            end
         endcase
      end
   end

   // outputs for this tick
   always_comb begin
      result.busy = (cur_phase != PH_IDLE);
      case (cur_phase)
         PH_HDR_MARK, PH_BIT_MARK, PH_RPT_MARK: result.mark = 1'b1;
         default:                               result.mark = 1'b0;
      endcase
   end

   // state registers, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         shift_ff     <= shift_in;
         bits_ff      <= bits_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/irpdt_out_reg.sv -----
// result register between the sequencer and the result channel
`timescale 1ns / 1ps
`default_nettype none
module irpdt_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire irpdt_pkg::result_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output irpdt_pkg::result_type   out_data
);
   import irpdt_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // a new result may load when empty or when the held one leaves
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- sim/ir_pulse_distance_transmitter_core_test.sv -----
// self-checking bench for the ir pulse-distance transmitter envelope generator
`timescale 1ns / 1ps
module ir_pulse_distance_transmitter_core_test;
   import irpdt_pkg::*;

   localparam int FRAME_BITS = 8;
   localparam int STALL_LIMIT = 1000;
   localparam int TICK_TARGET = 850;

   // predicts the mark envelope tick by tick and keeps the expected results
   class envelope_scoreboard;
      logic [LEN_W-1:0] lens [NUM_REGS];
      phase_type        ph;
      logic [LEN_W-1:0] ticks_left;
      logic [CMD_W-1:0] shifter;
      int               bits_todo;
      result_type       envelope_q [$];
      int               fails;
      int               checked;
      int               frames_started;

      function new();
         lens[REG_HDR_MARK]   = RST_HDR_MARK;
         lens[REG_HDR_SPACE]  = RST_HDR_SPACE;
         lens[REG_BIT_MARK]   = RST_BIT_MARK;
         lens[REG_ONE_SPACE]  = RST_ONE_SPACE;
         lens[REG_ZERO_SPACE] = RST_ZERO_SPACE;
         lens[REG_RPT_MARK]   = RST_RPT_MARK;
         lens[REG_RPT_SPACE]  = RST_RPT_SPACE;
         ph = PH_IDLE;
         ticks_left = '0;
         shifter = '0;
         bits_todo = 0;
         fails = 0;
         checked = 0;
         frames_started = 0;
      endfunction

      function void set_len(int idx, logic [LEN_W-1:0] value);
         lens[idx] = value;
      endfunction

      function bit in_frame();
         return ph != PH_IDLE;
      endfunction

      function int pending();
         return envelope_q.size();
      endfunction

      // a zero length still lasts one tick
      function void open_segment(phase_type next, logic [LEN_W-1:0] len);
         ph = next;
         ticks_left = (len == '0) ? LEN_W'(1) : len;
      endfunction

      function void close_segment(bit hold);
         case (ph)
            PH_HDR_MARK:  open_segment(PH_HDR_SPACE, lens[REG_HDR_SPACE]);
            PH_HDR_SPACE: open_segment(PH_BIT_MARK, lens[REG_BIT_MARK]);
            PH_BIT_MARK: begin
               if (shifter[0])
                  open_segment(PH_BIT_SPACE, lens[REG_ONE_SPACE]);
               else
                  open_segment(PH_BIT_SPACE, lens[REG_ZERO_SPACE]);
            end
            PH_BIT_SPACE: begin
               shifter = shifter >> 1;
               if (bits_todo > 0)
                  bits_todo--;
               if (bits_todo > 0)
                  open_segment(PH_BIT_MARK, lens[REG_BIT_MARK]);
               else
                  open_segment(PH_RPT_MARK, lens[REG_RPT_MARK]);
            end
            PH_RPT_MARK:  open_segment(PH_RPT_SPACE, lens[REG_RPT_SPACE]);
            PH_RPT_SPACE: begin
               if (hold) begin
                  open_segment(PH_RPT_MARK, lens[REG_RPT_MARK]);
               end else begin
                  ph = PH_IDLE;
                  ticks_left = '0;
               end
            end
            default: begin
               ph = PH_IDLE;
               ticks_left = '0;
            end
         endcase
      endfunction

      // one accepted tick: a start is taken only while idle
      function void note_tick(bit start, logic [CMD_W-1:0] cmd, bit hold);
         result_type want;
         if (ph == PH_IDLE && start) begin
            shifter = cmd;
            bits_todo = FRAME_BITS;
            open_segment(PH_HDR_MARK, lens[REG_HDR_MARK]);
            frames_started++;
         end
         want.mark = (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_RPT_MARK);
         want.busy = (ph != PH_IDLE);
         envelope_q.push_back(want);
         if (ph != PH_IDLE) begin
            if (ticks_left <= 1)
               close_segment(hold);
            else
               ticks_left--;
         end
      endfunction

      task report_mismatch(string msg);
         if (fails < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
         fails++;
      endtask

      task check_envelope(logic [7:0] data);
         result_type want;
         if (envelope_q.size() == 0) begin
            report_mismatch($sformatf("envelope result 0x%02h with none pending", data));
            return;
         end
         want = envelope_q.pop_front();
         checked++;
         if (data[0] !== want.mark)
            report_mismatch($sformatf("result %0d mark %b, want %b", checked, data[0],
                                      want.mark));
         if (data[1] !== want.busy)
            report_mismatch($sformatf("result %0d busy %b, want %b", checked, data[1],
                                      want.busy));
         if (data[7:2] !== 6'd0)
            report_mismatch($sformatf("result %0d pad bits 0x%02h", checked, data[7:2]));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;   // start_req[0], command[8:1], hold[9], zero pad
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;        // mark[0], busy_res[1], zero pad
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   envelope_scoreboard sb;
   logic [LEN_W-1:0]   plan [NUM_REGS];
   bit                 pace_free = 1'b0;
   int                 frame_ticks = 0;
   int                 quiet_cycles = 0;

   ir_pulse_distance_transmitter_core #(
      .BITS_PER_FRAME(FRAME_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // check every envelope transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_envelope(rsp_tdata);
   end

   // watchdog on cycles without any transfer or register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // sink side: random stall before each result, none in free-running stretches
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pace_free ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // one tick transfer, predicted at the edge that accepts it
   task automatic send_tick(input bit start, input logic [CMD_W-1:0] cmd, input bit hold);
      int gap;
      gap = pace_free ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, hold, cmd, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(start, cmd, hold);
   endtask

   // one apb transfer; psel stays up so accesses can run back to back
   task automatic csr_access(input bit wr, input int idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= ADDR_W'(idx * 4);
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   // write every length in plan, junk in the upper half, and read it back
   task automatic apply_plan();
      logic [31:0] got;
      logic [15:0] junk;
      for (int i = 0; i < NUM_REGS; i++) begin
         junk = 16'($urandom);
         csr_access(1'b1, i, {junk, plan[i]}, got);
         sb.set_len(i, plan[i]);
         csr_access(1'b0, i, 32'd0, got);
         if (got !== {16'd0, plan[i]})
            sb.report_mismatch($sformatf("register %0d reads 0x%08h, want 0x%04h", i, got,
                                         plan[i]));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // stop sending and wait for every predicted result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // a frame, sometimes with idle noise ahead, then ticks until the sequencer idles
   task automatic run_frame(input int hold_pct);
      int noise;
      int pick;
      logic [CMD_W-1:0] cmd;
      noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (noise) send_tick(1'b0, CMD_W'($urandom), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      cmd = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : CMD_W'($urandom);
      send_tick(1'b1, cmd, 1'($urandom_range(0, 1)));
      frame_ticks++;
      while (sb.in_frame()) begin
         send_tick(1'($urandom_range(0, 1)), CMD_W'($urandom),
                   $urandom_range(0, 99) < hold_pct);
         frame_ticks++;
      end
   endtask

   initial begin
      logic [LEN_W-1:0] defaults [NUM_REGS];
      logic [31:0]      got;
      int               nframes;
      int               hold_pct;
      int               pick;

      sb = new();
      defaults[REG_HDR_MARK]   = RST_HDR_MARK;
      defaults[REG_HDR_SPACE]  = RST_HDR_SPACE;
      defaults[REG_BIT_MARK]   = RST_BIT_MARK;
      defaults[REG_ONE_SPACE]  = RST_ONE_SPACE;
      defaults[REG_ZERO_SPACE] = RST_ZERO_SPACE;
      defaults[REG_RPT_MARK]   = RST_RPT_MARK;
      defaults[REG_RPT_SPACE]  = RST_RPT_SPACE;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // registers come out of reset with the package default lengths
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_access(1'b0, i, 32'd0, got);
         if (got !== {16'd0, defaults[i]})
            sb.report_mismatch($sformatf("register %0d resets to 0x%08h, want 0x%04h", i,
                                         got, defaults[i]));
      end
      csr_psel <= 1'b0;

      // one-tick segments, zero lengths on the bit mark and zero space
      for (int i = 0; i < NUM_REGS; i++)
         plan[i] = 16'd1;
      plan[REG_BIT_MARK] = 16'd0;
      plan[REG_ZERO_SPACE] = 16'd0;
      apply_plan();

      // hold while idle is ignored; start held high through a whole frame,
      // one extra repeat burst, then a start on the first idle tick
      send_tick(1'b0, 8'hFF, 1'b1);
      for (int k = 0; k <= 22; k++)
         send_tick(1'b1, (k == 0) ? 8'hFF : (k == 22) ? 8'h00 : CMD_W'($urandom), k == 19);
      while (sb.in_frame())
         send_tick(1'b0, CMD_W'($urandom), 1'b0);
      settle();

      // random phases: short segments, random commands and hold patterns
      while (frame_ticks < TICK_TARGET) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            pick = $urandom_range(0, 9);
            plan[i] = (pick < 7) ? LEN_W'($urandom_range(0, 5)) :
                      (pick == 7) ? 16'd0 : (pick == 8) ? 16'd1 :
                      LEN_W'($urandom_range(6, 24));
         end
         apply_plan();
         pace_free = ($urandom_range(0, 3) == 0);
         nframes = $urandom_range(2, 4);
         repeat (nframes) begin
            pick = $urandom_range(0, 3);
            hold_pct = (pick == 0) ? 0 : (pick == 1) ? 30 : (pick == 2) ? 70 : 90;
            run_frame(hold_pct);
         end
         settle();
      end

      // every length at its maximum; only the opening of the frame is run
      for (int i = 0; i < NUM_REGS; i++)
         plan[i] = 16'hFFFF;
      apply_plan();
      pace_free = 1'b0;
      send_tick(1'b1, CMD_W'($urandom), 1'b1);
      repeat (30)
         send_tick(1'($urandom_range(0, 1)), CMD_W'($urandom), 1'($urandom_range(0, 1)));
      settle();

      // idle cycles at the end to catch any stray result
      repeat (8) @(posedge clock);

      $display("frames started: %0d, envelope results checked: %0d", sb.frames_started,
               sb.checked);
      $display("segment lengths from 0 to 65535, random source gaps and sink stalls");
      if (sb.fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
